// ----- rtl/sat_pkg.sv -----
// sat_pkg: shared widths, constants, state and command types of the sine block
// used by sat_mul, sat_dp, sat_ctrl and sine_adaptive_taylor
`default_nettype none

package sat_pkg;

	// port field widths
	localparam int unsigned ANG_W  = 32;
	localparam int unsigned EPS_W  = 10;
	localparam int unsigned SIN_W  = 32;
	localparam int unsigned TU_W   = 5;

	// internal fixed-point widths, all Q.50 magnitudes unless noted
	localparam int unsigned Q_SH    = 30;             // Q12.20 to Q.50
	localparam int unsigned R_W     = ANG_W + Q_SH;   // |angle| in Q.50
	localparam int unsigned X_W     = 53;             // reduced angle, below 2*pi
	localparam int unsigned X2_W    = 56;             // x squared, below 40
	localparam int unsigned T_W     = 57;             // term magnitude, below 82
	localparam int unsigned P_W     = 62;             // term times x squared, below 3300
	localparam int unsigned SUM_W   = 60;             // signed partial sum, below 268
	localparam int unsigned OP_W    = 64;             // multiplier operand
	localparam int unsigned HALF_W  = OP_W / 2;       // one partial product operand
	localparam int unsigned ACC_W   = 2 * OP_W;       // full product
	localparam int unsigned FRAC_SH = 50;
	localparam int unsigned OUT_SH  = 20;             // Q.50 to Q1.30

	localparam int unsigned RED_STEPS = 9;            // quotient of the reduction < 512

	localparam logic [X_W-1:0]   TWO_PI_Q50 = 53'd7074237752028440;
	localparam logic [ACC_W-1:0] ROUND50    = ACC_W'(1) << (FRAC_SH - 1);
	localparam logic [SIN_W-1:0] ONE_Q30    = 32'h4000_0000;
	localparam logic [EPS_W-1:0] EPS_RESET  = 10'd11;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REDUCE,
		S_FOLD,
		S_SQ_GO,
		S_SQ_WAIT,
		S_TM_GO,
		S_TM_WAIT,
		S_DV_GO,
		S_DV_WAIT,
		S_ACC,
		S_ROUND,
		S_DONE
	} sat_state_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MOP_SQUARE,
		MOP_TERM,
		MOP_RECIP
	} sat_mop_t;

	typedef struct packed {
		logic     load;
		logic     red_step;
		logic     fold;
		logic     mul_go;
		sat_mop_t mop;
		logic     ld_x2;
		logic     ld_num;
		logic     ld_term;
		logic     add_term;
		logic     next_term;
		logic     round;
		logic     out_load;
	} sat_cmd_t;

	typedef struct packed {
		logic red_last;
		logic mul_done;
		logic term_small;
		logic at_limit;
		logic out_free;
	} sat_sts_t;

endpackage

`default_nettype wire

// ----- rtl/sat_mul.sv -----
// sat_mul: shared 64x64 multiplier built from one 32x32 multiplier,
// four partial products in turn; uses sat_pkg
`default_nettype none

module sat_mul import sat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             rnd,
	input  logic [OP_W-1:0]  op_a,
	input  logic [OP_W-1:0]  op_b,
	output logic             done,
	output logic [ACC_W-1:0] acc
);

	logic [OP_W-1:0]   a_q;
	logic [OP_W-1:0]   b_q;
	logic [1:0]        cnt_q;
	logic              run_q;
	logic [OP_W-1:0]   pp_s1;
	logic [1:0]        sh_s1;
	logic              vld_s1;
	logic              last_s1;
	logic              done_q;
	logic [ACC_W-1:0]  acc_q;
	logic [HALF_W-1:0] a_half;
	logic [HALF_W-1:0] b_half;
	logic [ACC_W-1:0]  pp_ext;

	assign a_half = cnt_q[0] ? a_q[OP_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half = cnt_q[1] ? b_q[OP_W-1:HALF_W] : b_q[HALF_W-1:0];

	always_comb begin
		unique case (sh_s1)
			2'd0:    pp_ext = ACC_W'(pp_s1);
			2'd1:    pp_ext = ACC_W'(pp_s1) << HALF_W;
			2'd2:    pp_ext = ACC_W'(pp_s1) << OP_W;
			default: pp_ext = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
			vld_s1  <= run_q;
			last_s1 <= run_q && (cnt_q == 2'd3);
			done_q  <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= rnd ? ROUND50 : '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
		if (run_q) begin
			pp_s1 <= a_half * b_half;
			sh_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

// ----- rtl/sat_dp.sv -----
// sat_dp: datapath of the sine block: range reduction, series terms,
// partial sum, rounding and output register; uses sat_pkg and sat_mul
`default_nettype none

module sat_dp import sat_pkg::*; #(
	parameter int unsigned MAX_TERMS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sat_cmd_t                cmd,
	output sat_sts_t                sts,
	input  logic signed [ANG_W-1:0] angle,
	input  logic [EPS_W-1:0]        eps,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [SIN_W-1:0] sine_value,
	output logic [TU_W-1:0]         terms_used,
	output logic                    converged
);

	localparam int unsigned IW   = $clog2(MAX_TERMS);
	localparam int unsigned LMAX = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1));
	localparam int unsigned LW   = $clog2(LMAX + 1);
	localparam int unsigned RCW  = $clog2(RED_STEPS);

	// per-term constants: reciprocal of d = (2n)(2n+1), its shift and d/2
	logic [OP_W-1:0] rcp_tab  [MAX_TERMS];
	logic [LW-1:0]   sh_tab   [MAX_TERMS];
	logic [P_W-1:0]  half_tab [MAX_TERMS];

	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tab
		localparam int unsigned N1 = g + 1;
		localparam int unsigned D  = (2 * N1) * (2 * N1 + 1);
		localparam int unsigned L  = $clog2(D);
		localparam logic [ACC_W-1:0] DW  = ACC_W'(D);
		localparam logic [ACC_W-1:0] RCP = ((ACC_W'(1) << (P_W + L)) + DW - ACC_W'(1)) / DW;
		assign rcp_tab[g]  = RCP[OP_W-1:0];
		assign sh_tab[g]   = LW'(L);
		assign half_tab[g] = P_W'(N1 * (2 * N1 + 1));
	end

	// range reduction
	logic                 neg_q;
	logic [R_W-1:0]       rem_q;
	logic [R_W-1:0]       dv_q;
	logic [RCW-1:0]       red_cnt_q;
	logic [ANG_W-1:0]     abs_ang;
	logic [X_W-1:0]       xr;
	logic [X_W-1:0]       xf;

	// series
	logic [X_W-1:0]          x_q;
	logic [X2_W-1:0]         x2_q;
	logic [T_W-1:0]          t_q;
	logic [P_W-1:0]          num_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] t_ext;
	logic [IW-1:0]           idx_q;
	logic                    conv_q;
	logic [T_W-1:0]          thr;
	logic [ACC_W-P_W-1:0]    q_hi;

	// multiplier hookup
	logic [OP_W-1:0]  mul_a;
	logic [OP_W-1:0]  mul_b;
	logic             mul_done;
	logic [ACC_W-1:0] mul_acc;

	// rounding and output
	logic [SUM_W-1:0]        mag;
	logic [SUM_W-1:0]        mag_r;
	logic [SUM_W-OUT_SH-1:0] rmag;
	logic [SIN_W-1:0]        satm;
	logic [SIN_W-1:0]        res;
	logic signed [SIN_W-1:0] res_q;
	logic [IW:0]             used;
	logic                    out_valid_q;
	logic signed [SIN_W-1:0] sine_q;
	logic [TU_W-1:0]         used_q;
	logic                    conv_out_q;

	assign abs_ang = angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
	assign xr      = rem_q[X_W-1:0];
	assign xf      = (neg_q && (xr != '0)) ? (TWO_PI_Q50 - xr) : xr;

	always_comb begin
		unique case (cmd.mop)
			MOP_SQUARE: begin
				mul_a = OP_W'(x_q);
				mul_b = OP_W'(x_q);
			end
			MOP_TERM: begin
				mul_a = OP_W'(t_q);
				mul_b = OP_W'(x2_q);
			end
			MOP_RECIP: begin
				mul_a = OP_W'(num_q);
				mul_b = rcp_tab[idx_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sat_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_go),
		.rnd    (cmd.mop != MOP_RECIP),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.acc    (mul_acc)
	);

	assign q_hi  = mul_acc[ACC_W-1:P_W] >> sh_tab[idx_q];
	assign t_ext = signed'(SUM_W'(t_q));
	assign thr   = T_W'(eps) << OUT_SH;

	assign mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign mag_r = mag + (SUM_W'(1) << (OUT_SH - 1));
	assign rmag  = mag_r[SUM_W-1:OUT_SH];
	assign satm  = (rmag > (SUM_W-OUT_SH)'(ONE_Q30)) ? ONE_Q30 : SIN_W'(rmag);
	assign res   = sum_q[SUM_W-1] ? SIN_W'(-satm) : satm;
	assign used  = (IW+1)'(idx_q) + (IW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_cnt_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				red_cnt_q <= '0;
			end else if (cmd.red_step) begin
				red_cnt_q <= red_cnt_q + RCW'(1);
			end
			if (cmd.fold) begin
				idx_q <= '0;
			end else if (cmd.next_term) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= angle[ANG_W-1];
			rem_q <= {abs_ang, Q_SH'(0)};
			dv_q  <= R_W'(TWO_PI_Q50) << (RED_STEPS - 1);
		end else if (cmd.red_step) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.fold) begin
			x_q   <= xf;
			t_q   <= T_W'(xf);
			sum_q <= signed'(SUM_W'(xf));
		end else begin
			if (cmd.ld_term) begin
				t_q <= q_hi[T_W-1:0];
			end
			if (cmd.add_term) begin
				// odd n subtracts
				sum_q  <= idx_q[0] ? (sum_q + t_ext) : (sum_q - t_ext);
				conv_q <= (t_q <= thr);
			end
		end
		if (cmd.ld_x2) begin
			x2_q <= mul_acc[FRAC_SH +: X2_W];
		end
		if (cmd.ld_num) begin
			num_q <= mul_acc[FRAC_SH +: P_W] + half_tab[idx_q];
		end
		if (cmd.round) begin
			res_q <= signed'(res);
		end
		if (cmd.out_load) begin
			sine_q     <= res_q;
			used_q     <= TU_W'(used);
			conv_out_q <= conv_q;
		end
	end

	assign sts.red_last   = (red_cnt_q == RCW'(RED_STEPS - 1));
	assign sts.mul_done   = mul_done;
	assign sts.term_small = (t_q <= thr);
	assign sts.at_limit   = (idx_q == IW'(MAX_TERMS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign sine_value = sine_q;
	assign terms_used = used_q;
	assign converged  = conv_out_q;

endmodule

`default_nettype wire

// ----- rtl/sat_ctrl.sv -----
// sat_ctrl: sequencer of the sine block, drives sat_dp by command struct
// and follows its status struct; uses sat_pkg
`default_nettype none

module sat_ctrl import sat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sat_sts_t sts,
	output sat_cmd_t cmd
);

	sat_state_t state_q;
	sat_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_REDUCE;
			S_REDUCE:  if (sts.red_last) state_d = S_FOLD;
			S_FOLD:    state_d = S_SQ_GO;
			S_SQ_GO:   state_d = S_SQ_WAIT;
			S_SQ_WAIT: if (sts.mul_done) state_d = S_TM_GO;
			S_TM_GO:   state_d = S_TM_WAIT;
			S_TM_WAIT: if (sts.mul_done) state_d = S_DV_GO;
			S_DV_GO:   state_d = S_DV_WAIT;
			S_DV_WAIT: if (sts.mul_done) state_d = S_ACC;
			S_ACC: begin
				if (sts.term_small || sts.at_limit) begin
					state_d = S_ROUND;
				end else begin
					state_d = S_TM_GO;
				end
			end
			S_ROUND:   state_d = S_DONE;
			S_DONE:    if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_REDUCE:  cmd.red_step = 1'b1;
			S_FOLD:    cmd.fold = 1'b1;
			S_SQ_GO: begin
				cmd.mul_go = 1'b1;
				cmd.mop    = MOP_SQUARE;
			end
			S_SQ_WAIT: cmd.ld_x2 = sts.mul_done;
			S_TM_GO: begin
				cmd.mul_go = 1'b1;
				cmd.mop    = MOP_TERM;
			end
			S_TM_WAIT: cmd.ld_num = sts.mul_done;
			S_DV_GO: begin
				cmd.mul_go = 1'b1;
				cmd.mop    = MOP_RECIP;
			end
			S_DV_WAIT: cmd.ld_term = sts.mul_done;
			S_ACC: begin
				cmd.add_term  = 1'b1;
				cmd.next_term = !(sts.term_small || sts.at_limit);
			end
			S_ROUND:   cmd.round = 1'b1;
			S_DONE:    cmd.out_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/sine_adaptive_taylor.sv -----
// sine_adaptive_taylor: top level of the adaptive Taylor-series sine block
// holds the epsilon register; uses sat_pkg, sat_ctrl and sat_dp
//
// Takes a signed Q12.20 angle, reduces it modulo 2*pi into [0, 2*pi) with a
// restoring shift-and-subtract, then sums the sine series
// one term at a time, each term being the previous one times x^2/((2n)(2n+1))
// with alternating sign. Both steps of a term go through one shared 32x32
// multiplier, four partial products per 64x64 product: first the previous
// term times x^2, then the rounded numerator times a constant reciprocal of
// (2n)(2n+1), which gives the exact rounded quotient. The sum stops after the
// first added term at or below epsilon_lsb result LSBs, or after MAX_TERMS
// terms; the result is rounded to Q1.30 and saturated to plus/minus one.
// One item is in work at a time; the time from the input transfer to
// out_valid grows with terms_used, as each term takes two products on the
// shared multiplier.
// A finished result sits in the output register, so the next angle is taken
// while the previous result waits for out_ready. epsilon_lsb is written
// through the cfg channel, which is always ready; write it only while idle.
`default_nettype none

module sine_adaptive_taylor import sat_pkg::*; #(
	parameter int unsigned MAX_TERMS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// angle channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [ANG_W-1:0] angle,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SIN_W-1:0] sine_value,
	output logic [TU_W-1:0]         terms_used,
	output logic                    converged,
	// epsilon register write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [EPS_W-1:0]        epsilon_lsb
);

	logic [EPS_W-1:0] eps_q;
	sat_cmd_t         cmd;
	sat_sts_t         sts;

	// stop threshold, one register, taken on every cfg transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= epsilon_lsb;
		end
	end

	assign cfg_ready = 1'b1;

	// sequencer
	sat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// reduction, series, rounding and output register
	sat_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.angle      (angle),
		.eps        (eps_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.sine_value (sine_value),
		.terms_used (terms_used),
		.converged  (converged)
	);

	// an accepted angle takes the block out of idle for the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transfer");

	// saturation keeps the result within plus/minus one
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((sine_value <= 32'sh4000_0000) && (sine_value >= -32'sh4000_0000)))
		else $error("sine_value outside plus/minus one");

	// a result that did not converge used the full term budget
	a_limit_terms: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !converged) |-> (terms_used == TU_W'(MAX_TERMS)))
		else $error("unconverged result below the term limit");

endmodule

`default_nettype wire
